[rtl/core/ppb_pkg.sv]
// ----------------------------------------------------------------------------
// ppb_pkg
// Shared widths, codes and stage structs of the phosphor persistence blend.
// ----------------------------------------------------------------------------
package ppb_pkg;

   localparam int unsigned FRAME_PIXELS_DEF = 262144;

   localparam int unsigned IDX_W   = 18;
   localparam int unsigned CH_W    = 8;
   localparam int unsigned PIX_W   = 3 * CH_W;
   localparam int unsigned FADE_W  = 7;
   // wide enough to hold the largest frame size itself
   localparam int unsigned EXT_W   = 25;
   localparam int unsigned TDATA_W = 48;
   localparam int unsigned PAD_W   = TDATA_W - IDX_W - 3 * CH_W;

   localparam int unsigned CSR_ADDR_W = 3;
   localparam int unsigned CSR_DATA_W = 32;

   localparam logic [FADE_W-1:0] FADE_RESET = 7'd85;
   localparam logic [CH_W-1:0]   CH_MAX     = 8'hFF;

   // divide by one hundred as multiply by 5243 and shift by 19, exact below 2^15
   localparam int unsigned PROD_W    = CH_W + FADE_W;
   localparam int unsigned RECIP_W   = 13;
   localparam int unsigned DIV_RECIP = 5243;
   localparam int unsigned DIV_SHIFT = 19;
   localparam int unsigned SCALE_W   = PROD_W + RECIP_W;
   localparam int unsigned QUOT_W    = SCALE_W - DIV_SHIFT;

   typedef enum logic [0:0] {
      REQ_PIXEL       = 1'b0,
      REQ_TRAIL_RESET = 1'b1
   } req_kind_type;

   typedef enum logic [0:0] {
      REG_FADE = 1'b0
   } reg_index_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [PIX_W-1:0] rgb;
      logic             in_range;
      logic             primed;
   } item_type;

   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] idx;
   } slot_type;

   typedef struct packed {
      logic             en;
      logic [IDX_W-1:0] idx;
      logic [PIX_W-1:0] data;
   } wr_type;

   typedef struct packed {
      logic [IDX_W-1:0] idx;
      logic [CH_W-1:0]  red;
      logic [CH_W-1:0]  green;
      logic [CH_W-1:0]  blue;
   } result_type;

endpackage

[rtl/core/ppb_ram.sv]
// ----------------------------------------------------------------------------
// ppb_ram
// Generic single-write, single-read RAM with registered read (read-first).
// ----------------------------------------------------------------------------
module ppb_ram #(
   parameter int unsigned WIDTH  = 8,
   parameter int unsigned DEPTH  = 16,
   parameter int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/ppb_csr.sv]
// ----------------------------------------------------------------------------
// ppb_csr
// Register file: the fade percentage, written and read over the csr port.
// ----------------------------------------------------------------------------
module ppb_csr (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [ppb_pkg::CSR_ADDR_W-1:0]    csr_paddr,
   input  logic [ppb_pkg::CSR_DATA_W-1:0]    csr_pwdata,
   output logic [ppb_pkg::CSR_DATA_W-1:0]    csr_prdata,
   output logic [ppb_pkg::FADE_W-1:0]        fade
);
   import ppb_pkg::*;

   logic [FADE_W-1:0] fade_ff;
   logic [FADE_W-1:0] fade_in;
   reg_index_type     reg_sel;
   logic              wr_hit;

   // byte offset bits are ignored, word index selects the register
   assign reg_sel = reg_index_type'(csr_paddr[CSR_ADDR_W-1]);
   assign wr_hit  = csr_psel && csr_penable && csr_pwrite && (reg_sel == REG_FADE);

   always_comb begin
      fade_in = fade_ff;
      if (wr_hit) begin
         fade_in = csr_pwdata[FADE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fade_ff <= FADE_RESET;
      end else begin
         fade_ff <= fade_in;
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_FADE: csr_prdata = CSR_DATA_W'(fade_ff);
         default:  csr_prdata = '0;
      endcase
   end

   assign fade = fade_ff;

endmodule

[rtl/core/ppb_blend.sv]
// ----------------------------------------------------------------------------
// ppb_blend
// Two-stage read-modify-write datapath: trail select and fade multiply,
// then divide by one hundred, saturate, per-channel max and write-back.
// ----------------------------------------------------------------------------
module ppb_blend (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       adv,
   input  logic                       in_valid,
   input  ppb_pkg::item_type          in_item,
   input  logic [ppb_pkg::FADE_W-1:0] fade,
   input  logic [ppb_pkg::PIX_W-1:0]  rd_data,
   output ppb_pkg::slot_type          s1_slot,
   output ppb_pkg::wr_type            wr,
   output logic                       res_valid,
   output ppb_pkg::result_type        res
);
   import ppb_pkg::*;

   typedef struct packed {
      logic [IDX_W-1:0]  idx;
      logic [PIX_W-1:0]  rgb;
      logic              in_range;
      logic              use_trail;
      logic [PROD_W-1:0] prod_r;
      logic [PROD_W-1:0] prod_g;
      logic [PROD_W-1:0] prod_b;
   } stage2_type;

   function automatic logic [CH_W-1:0] div100_sat(input logic [PROD_W-1:0] prod);
      logic [SCALE_W-1:0] scaled;
      logic [QUOT_W-1:0]  quot;
      scaled = SCALE_W'(prod) * SCALE_W'(DIV_RECIP);
      quot   = scaled[SCALE_W-1:DIV_SHIFT];
      return (quot > QUOT_W'(CH_MAX)) ? CH_MAX : quot[CH_W-1:0];
   endfunction

   function automatic logic [CH_W-1:0] ch_max(input logic [CH_W-1:0] a,
                                              input logic [CH_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   logic       s1_valid_ff, s1_valid_in;
   item_type   s1_item_ff;
   logic       s2_valid_ff, s2_valid_in;
   stage2_type s2_ff, s2_in;
   logic             lw_valid_ff, lw_valid_in;
   logic [IDX_W-1:0] lw_idx_ff;
   logic [PIX_W-1:0] lw_data_ff;
   logic [PIX_W-1:0] trail;
   logic [CH_W-1:0]  dec_r, dec_g, dec_b;
   logic [CH_W-1:0]  out_r, out_g, out_b;

   // a write landing on the same edge as this word's read is not in rd_data yet
   assign trail = (lw_valid_ff && (lw_idx_ff == s1_item_ff.idx)) ? lw_data_ff : rd_data;

   always_comb begin
      s1_valid_in = adv ? in_valid : s1_valid_ff;
      s2_valid_in = adv ? s1_valid_ff : s2_valid_ff;
      s2_in.idx       = s1_item_ff.idx;
      s2_in.rgb       = s1_item_ff.rgb;
      s2_in.in_range  = s1_item_ff.in_range;
      s2_in.use_trail = s1_item_ff.primed && s1_item_ff.in_range;
      s2_in.prod_r    = PROD_W'(trail[3*CH_W-1:2*CH_W]) * PROD_W'(fade);
      s2_in.prod_g    = PROD_W'(trail[2*CH_W-1:CH_W]) * PROD_W'(fade);
      s2_in.prod_b    = PROD_W'(trail[CH_W-1:0]) * PROD_W'(fade);
   end

   always_comb begin
      dec_r = div100_sat(s2_ff.prod_r);
      dec_g = div100_sat(s2_ff.prod_g);
      dec_b = div100_sat(s2_ff.prod_b);
      out_r = s2_ff.rgb[3*CH_W-1:2*CH_W];
      out_g = s2_ff.rgb[2*CH_W-1:CH_W];
      out_b = s2_ff.rgb[CH_W-1:0];
      if (s2_ff.use_trail) begin
         out_r = ch_max(out_r, dec_r);
         out_g = ch_max(out_g, dec_g);
         out_b = ch_max(out_b, dec_b);
      end
   end

   assign wr.en   = adv && s2_valid_ff && s2_ff.in_range;
   assign wr.idx  = s2_ff.idx;
   assign wr.data = {out_r, out_g, out_b};

   assign lw_valid_in = lw_valid_ff || wr.en;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         lw_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         lw_valid_ff <= lw_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_item_ff <= in_item;
         s2_ff      <= s2_in;
      end
      if (wr.en) begin
         lw_idx_ff  <= wr.idx;
         lw_data_ff <= wr.data;
      end
   end

   assign s1_slot.valid = s1_valid_ff && s1_item_ff.in_range;
   assign s1_slot.idx   = s1_item_ff.idx;

   assign res_valid = s2_valid_ff;
   assign res.idx   = s2_ff.idx;
   assign res.red   = out_r;
   assign res.green = out_g;
   assign res.blue  = out_b;

endmodule

[rtl/core/phosphor_persistence_blend_top.sv]
// ----------------------------------------------------------------------------
// phosphor_persistence_blend_top
// Per-pixel phosphor trail: decays the stored pixel by the fade percentage,
// keeps the brighter of it and the new pixel, and writes the result back.
// ----------------------------------------------------------------------------
//  channel | ports  | handshake          | payload
//  --------+--------+--------------------+-----------------------------------
//  request | req_*  | tvalid/tready      | tdata: index, red, green, blue;
//          |        |                    | tuser: kind; tlast: frame end
//  result  | rsp_*  | tvalid/tready      | tdata: index, red, green, blue
//  csr     | csr_*  | psel/penable/pwrite| fade percentage at word 0
//
//  one pixel word per clock unless the result side stalls; each result
//  leaves the blend stages into an output register so input keeps flowing.
//  a pixel is held off while it hits the same in-frame index as the pixel
//  word still in the first stage (trail read-modify-write turnaround).
//  trail-reset words are taken every clock and give no result.
//  reset clears only control state; the trail memory needs no clearing pass.
// ----------------------------------------------------------------------------
module phosphor_persistence_blend_top #(
   parameter int unsigned FRAME_PIXELS = ppb_pkg::FRAME_PIXELS_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // [17:0] pixel_index, [25:18] red_in, [33:26] green_in, [41:34] blue_in
   input  logic [ppb_pkg::TDATA_W-1:0]    req_tdata,
   // [0] req_type
   input  logic                           req_tuser,
   input  logic                           req_tlast,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // [17:0] pixel_index_out, [25:18] red_out, [33:26] green_out,
   // [41:34] blue_out
   output logic [ppb_pkg::TDATA_W-1:0]    rsp_tdata,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [ppb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [ppb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [ppb_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import ppb_pkg::*;

   localparam int unsigned ADDR_W = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;

   logic [FADE_W-1:0] fade;
   logic [IDX_W-1:0]  req_idx;
   logic [EXT_W-1:0]  req_idx_ext;
   logic [EXT_W-1:0]  wr_idx_ext;
   req_kind_type      req_kind;
   logic              adv;
   logic              hazard;
   logic              accept_px;
   logic              accept_rst;
   item_type          in_item;
   slot_type          s1_slot;
   wr_type            wr;
   logic              res_valid;
   result_type        res;
   logic [PIX_W-1:0]  rd_data;
   logic              primed_ff, primed_in;
   logic              rsp_valid_ff, rsp_valid_in;
   result_type        rsp_ff;

   ppb_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .fade        (fade)
   );
   assign csr_pready = 1'b1;

   assign req_idx     = req_tdata[IDX_W-1:0];
   assign req_idx_ext = EXT_W'(req_idx);
   assign wr_idx_ext  = EXT_W'(wr.idx);
   assign req_kind    = req_kind_type'(req_tuser);

   // pipeline moves whenever the output register is free or draining
   assign adv    = !rsp_valid_ff || rsp_tready;
   assign hazard = s1_slot.valid && (s1_slot.idx == req_idx);

   always_comb begin
      unique case (req_kind)
         REQ_TRAIL_RESET: req_tready = 1'b1;
         default:         req_tready = adv && !hazard;
      endcase
   end

   assign accept_px  = req_tvalid && req_tready && (req_kind == REQ_PIXEL);
   assign accept_rst = req_tvalid && req_tready && (req_kind == REQ_TRAIL_RESET);

   assign in_item.idx      = req_idx;
   assign in_item.rgb      = {req_tdata[IDX_W+CH_W-1:IDX_W],
                              req_tdata[IDX_W+2*CH_W-1:IDX_W+CH_W],
                              req_tdata[IDX_W+3*CH_W-1:IDX_W+2*CH_W]};
   assign in_item.in_range = req_idx_ext < EXT_W'(FRAME_PIXELS);
   assign in_item.primed   = primed_ff;

   always_comb begin
      primed_in = primed_ff;
      priority if (accept_rst) begin
         primed_in = 1'b0;
      end else if (accept_px && req_tlast) begin
         primed_in = 1'b1;
      end else begin
         primed_in = primed_ff;
      end
   end

   ppb_ram #(
      .WIDTH  (PIX_W),
      .DEPTH  (FRAME_PIXELS),
      .ADDR_W (ADDR_W)
   ) u_trail_ram (
      .clock   (clock),
      .wr_en   (wr.en),
      .wr_addr (wr_idx_ext[ADDR_W-1:0]),
      .wr_data (wr.data),
      .rd_en   (accept_px),
      .rd_addr (req_idx_ext[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   ppb_blend u_blend (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (accept_px),
      .in_item   (in_item),
      .fade      (fade),
      .rd_data   (rd_data),
      .s1_slot   (s1_slot),
      .wr        (wr),
      .res_valid (res_valid),
      .res       (res)
   );

   assign rsp_valid_in = adv ? res_valid : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         primed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         primed_ff    <= primed_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && res_valid) begin
         rsp_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{PAD_W{1'b0}}, rsp_ff.blue, rsp_ff.green, rsp_ff.red, rsp_ff.idx};

endmodule

[rtl/core/ppb_checker.sv]
// ----------------------------------------------------------------------------
// ppb_checker
// Port-level checks of the phosphor persistence blend, bound to the top.
// ----------------------------------------------------------------------------
module ppb_checker (
   input logic                           clock,
   input logic                           reset,
   input logic                           req_tvalid,
   input logic                           req_tready,
   input logic                           req_tuser,
   input logic                           rsp_tvalid,
   input logic                           rsp_tready,
   input logic [ppb_pkg::TDATA_W-1:0]    rsp_tdata,
   input logic                           csr_psel,
   input logic                           csr_penable,
   input logic                           csr_pwrite,
   input logic [ppb_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input logic [ppb_pkg::CSR_DATA_W-1:0] csr_pwdata,
   input logic [ppb_pkg::CSR_DATA_W-1:0] csr_prdata,
   input logic                           csr_pready
);
   import ppb_pkg::*;

   logic fade_wr;
   assign fade_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                    (csr_paddr[CSR_ADDR_W-1] == REG_FADE);

   // no result may be left over from before reset
   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result word visible right after reset");

   // a stalled result word holds
   a_rsp_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed or dropped while stalled");

   // trail-reset words never wait, they touch neither memory nor output
   a_trail_reset_ready : assert property (@(posedge clock) disable iff (reset)
      req_tvalid && (req_tuser == REQ_TRAIL_RESET) |-> req_tready)
      else $error("trail-reset word held off");

   // fade written is read back on the next cycle
   a_fade_readback : assert property (@(posedge clock) disable iff (reset)
      fade_wr |=> (csr_paddr[CSR_ADDR_W-1] != REG_FADE) ||
                  (csr_prdata[FADE_W-1:0] == $past(csr_pwdata[FADE_W-1:0])))
      else $error("fade register readback mismatch");

endmodule

bind phosphor_persistence_blend_top ppb_checker u_ppb_checker (.*);

[bench/phosphor_persistence_blend_top_tb.sv]
// ----------------------------------------------------------------------------
// phosphor_persistence_blend_top_tb
// Streams pixel frames through the trail blender with random gaps on the
// request side and random back-pressure on the result side. A behavioural
// trail model predicts every blended pixel, and the result stream is checked
// field by field. The fade percentage is changed between drained phases.
// ----------------------------------------------------------------------------
module phosphor_persistence_blend_top_tb;
   import ppb_pkg::*;

   // a short frame keeps every frame cheap and makes out-of-frame indices easy
   localparam int unsigned FRAME_LEN  = 16;
   localparam int unsigned MIRROR_AW  = $clog2(FRAME_LEN);
   localparam int unsigned PHASES     = 6;
   localparam int unsigned BATCH_LEN  = 108;
   localparam int unsigned SETTLE     = 8;

   typedef struct packed {
      req_kind_type     kind;
      logic [IDX_W-1:0] idx;
      logic [CH_W-1:0]  red;
      logic [CH_W-1:0]  green;
      logic [CH_W-1:0]  blue;
      logic             frame_end;
   } pixel_word_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [TDATA_W-1:0]    req_tdata = '0;
   logic                  req_tuser = 1'b0;
   logic                  req_tlast = 1'b0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [TDATA_W-1:0]    rsp_tdata;
   logic                  csr_psel = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // trail mirror
   logic [PIX_W-1:0]  trail_mirror [FRAME_LEN];
   logic              trail_primed = 1'b0;
   logic [FADE_W-1:0] fade_setting = FADE_RESET;

   pixel_word_type pending_words [$];
   result_type     expected_blends [$];
   pixel_word_type word_on_bus;

   int unsigned sender_idle_pct = 16;
   int unsigned receiver_idle_pct = 70;
   int unsigned words_taken = 0;
   int unsigned blends_checked = 0;
   int unsigned fade_writes = 0;
   int unsigned error_count = 0;

   phosphor_persistence_blend_top #(
      .FRAME_PIXELS(FRAME_LEN)
   ) uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   always #10 clock = ~clock;

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch: %s got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   function automatic logic [CH_W-1:0] faded(input logic [CH_W-1:0] c);
      int d;
      d = (int'(c) * int'(fade_setting)) / 100;
      return (d > 255) ? CH_MAX : d[CH_W-1:0];
   endfunction

   function automatic logic [CH_W-1:0] brighter(input logic [CH_W-1:0] a,
                                                input logic [CH_W-1:0] b);
      return (a > b) ? a : b;
   endfunction

   task automatic predict_blend(input pixel_word_type w);
      logic [PIX_W-1:0] prev;
      result_type       res;
      if (w.kind == REQ_TRAIL_RESET) begin
         trail_primed = 1'b0;
      end else begin
         res.idx   = w.idx;
         res.red   = w.red;
         res.green = w.green;
         res.blue  = w.blue;
         if (w.idx < FRAME_LEN) begin
            if (trail_primed) begin
               prev      = trail_mirror[w.idx[MIRROR_AW-1:0]];
               res.red   = brighter(res.red,   faded(prev[23:16]));
               res.green = brighter(res.green, faded(prev[15:8]));
               res.blue  = brighter(res.blue,  faded(prev[7:0]));
            end
            trail_mirror[w.idx[MIRROR_AW-1:0]] = {res.red, res.green, res.blue};
         end
         if (w.frame_end)
            trail_primed = 1'b1;
         expected_blends.push_back(res);
      end
   endtask

   task automatic check_blend(input logic [TDATA_W-1:0] data);
      result_type want;
      if (expected_blends.size() == 0) begin
         $display("mismatch: unexpected result word %h at %0t", data, $realtime);
         error_count++;
      end else begin
         want = expected_blends.pop_front();
         blends_checked++;
         if (data[17:0] !== want.idx)
            report_mismatch("pixel index", data[17:0], want.idx);
         if (data[25:18] !== want.red)
            report_mismatch("red", data[25:18], want.red);
         if (data[33:26] !== want.green)
            report_mismatch("green", data[33:26], want.green);
         if (data[41:34] !== want.blue)
            report_mismatch("blue", data[41:34], want.blue);
      end
   endtask

   // request driver: valid is held until the word is taken
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            predict_blend(word_on_bus);
            words_taken++;
         end
         if (!req_tvalid || req_tready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               word_on_bus = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tdata  <= {{PAD_W{1'b0}}, word_on_bus.blue, word_on_bus.green,
                              word_on_bus.red, word_on_bus.idx};
               req_tuser  <= word_on_bus.kind;
               req_tlast  <= word_on_bus.frame_end;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // result monitor with random back-pressure
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready)
            check_blend(rsp_tdata);
         rsp_tready <= ($urandom_range(99) >= receiver_idle_pct);
      end
   end

   task automatic csr_access(input logic write, input logic [CSR_DATA_W-1:0] wdata,
                             output logic [CSR_DATA_W-1:0] rdata);
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CSR_ADDR_W'(4 * int'(REG_FADE));
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      rdata = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_fade(input logic [FADE_W-1:0] value);
      logic [CSR_DATA_W-1:0] rd;
      csr_access(1'b1, CSR_DATA_W'(value), rd);
      fade_setting = value;
      fade_writes++;
      csr_access(1'b0, '0, rd);
      if (rd[FADE_W-1:0] !== value)
         report_mismatch("fade read-back", rd[FADE_W-1:0], value);
   endtask

   function automatic logic [CH_W-1:0] random_channel();
      case ($urandom_range(7))
         0:       return '0;
         1:       return CH_MAX;
         default: return CH_W'($urandom_range(255));
      endcase
   endfunction

   task automatic push_pixel(input int unsigned idx, input logic [CH_W-1:0] r,
                             input logic [CH_W-1:0] g, input logic [CH_W-1:0] b,
                             input logic fe);
      pending_words.push_back('{REQ_PIXEL, IDX_W'(idx), r, g, b, fe});
   endtask

   task automatic push_trail_reset();
      pending_words.push_back('{REQ_TRAIL_RESET, IDX_W'($urandom), random_channel(),
                                random_channel(), random_channel(),
                                1'($urandom_range(1))});
   endtask

   // mostly whole frames with random content, the rest stray words
   task automatic fill_batch(input int unsigned count);
      int unsigned order [FRAME_LEN];
      int unsigned pushed;
      int unsigned j;
      int unsigned tmp;
      pushed = 0;
      while (pushed < count) begin
         if ($urandom_range(99) < 75) begin
            if ($urandom_range(5) == 0) begin
               push_trail_reset();
               pushed++;
            end
            for (int i = 0; i < FRAME_LEN; i++)
               order[i] = i;
            if ($urandom_range(2) != 0) begin
               for (int i = FRAME_LEN - 1; i > 0; i--) begin
                  j        = $urandom_range(i);
                  tmp      = order[i];
                  order[i] = order[j];
                  order[j] = tmp;
               end
            end
            for (int i = 0; i < FRAME_LEN; i++) begin
               if ($urandom_range(9) == 0) begin
                  push_pixel(order[i], random_channel(), random_channel(),
                             random_channel(), 1'b0);
                  pushed++;
               end
               if ($urandom_range(19) == 0) begin
                  push_pixel($urandom_range(2**IDX_W - 1, FRAME_LEN), random_channel(),
                             random_channel(), random_channel(), 1'b0);
                  pushed++;
               end
               push_pixel(order[i], random_channel(), random_channel(), random_channel(),
                          i == FRAME_LEN - 1);
               pushed++;
            end
         end else if ($urandom_range(3) == 0) begin
            push_trail_reset();
            pushed++;
         end else begin
            push_pixel($urandom_range(2**IDX_W - 1), random_channel(), random_channel(),
                       random_channel(), 1'($urandom_range(1)));
            pushed++;
         end
      end
   endtask

   // also the point where the sender holds off until every result is in
   task automatic drain();
      while (pending_words.size() != 0 || req_tvalid || expected_blends.size() != 0)
         @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   initial begin
      logic [FADE_W-1:0] fade_plan [PHASES];
      fade_plan[0] = 7'd100;
      fade_plan[1] = 7'd0;
      fade_plan[2] = 7'd127;
      fade_plan[3] = FADE_W'($urandom_range(99, 1));
      fade_plan[4] = FADE_W'($urandom_range(127, 101));
      fade_plan[5] = FADE_W'($urandom_range(127));

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // seeding frame writes every trail entry before anything is read back
      push_pixel(0, 8'h00, 8'h00, 8'h00, 1'b0);
      push_pixel(1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      push_pixel(2, 8'hFF, 8'h00, 8'h80, 1'b0);
      for (int i = 3; i < FRAME_LEN; i++)
         push_pixel(i, CH_W'(i * 17), CH_W'(255 - i * 17), CH_W'(8'hAA ^ i),
                    i == FRAME_LEN - 1);
      // primed blend, same index twice in a row
      push_pixel(5, 8'h00, 8'h00, 8'h00, 1'b0);
      push_pixel(5, 8'h10, 8'hFF, 8'h01, 1'b0);
      // beyond the frame: passes through and leaves the trail alone
      push_pixel(2**IDX_W - 1, 8'hFF, 8'hFF, 8'hFF, 1'b0);
      // trail drop, its frame end is ignored
      pending_words.push_back('{REQ_TRAIL_RESET, {IDX_W{1'b1}}, 8'hFF, 8'hFF, 8'hFF, 1'b1});
      // out-of-frame last pixel still primes
      push_pixel(FRAME_LEN, 8'h55, 8'hAA, 8'h0F, 1'b1);
      push_pixel(0, 8'h00, 8'h00, 8'h00, 1'b0);
      drain();

      for (int p = 0; p < PHASES; p++) begin
         case (p / 2)
            0: begin
               sender_idle_pct   = 16;
               receiver_idle_pct = 70;
            end
            1: begin
               sender_idle_pct   = 70;
               receiver_idle_pct = 16;
            end
            default: begin
               sender_idle_pct   = 0;
               receiver_idle_pct = 0;
            end
         endcase
         set_fade(fade_plan[p]);
         fill_batch(BATCH_LEN);
         drain();
      end

      $display("%0d words sent, %0d blended pixels checked", words_taken, blends_checked);
      $display("%0d fade settings written, from zero to the 7-bit maximum", fade_writes);
      if (error_count == 0) begin
         $display("phosphor_persistence_blend_top_tb OK");
      end else begin
         $display("phosphor_persistence_blend_top_tb NOT OK");
      end
      $finish;
   end

   initial begin
      #4000000;
      $display("timeout with %0d results outstanding", expected_blends.size());
      $display("phosphor_persistence_blend_top_tb NOT OK");
      $finish;
   end

endmodule
